>>> rtl/fap_pkg.sv
// Shared constants, mode codes and pipeline payload type for the fixed-point ALU.
// Used by fixed_point_alu_top and the testbench; depends on nothing else.
package fap_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    // The widened dividend holds |a| shifted left by FRAC_BITS.
    localparam int DIV_W     = DATA_W + FRAC_BITS;
    // Input register, operand stage, one stage per quotient bit, output register.
    localparam int LATENCY   = DIV_W + 3;

    typedef enum logic [3:0] {
        MODE_ADD     = 4'd0,
        MODE_SUB     = 4'd1,
        MODE_MUL     = 4'd2,
        MODE_DIV     = 4'd3,
        MODE_GT      = 4'd4,
        MODE_LT      = 4'd5,
        MODE_GE      = 4'd6,
        MODE_LE      = 4'd7,
        MODE_EQ      = 4'd8,
        MODE_NE      = 4'd9,
        MODE_MIN     = 4'd10,
        MODE_MAX     = 4'd11,
        MODE_INC     = 4'd12,
        MODE_DEC     = 4'd13,
        MODE_TOINT   = 4'd14,
        MODE_FROMINT = 4'd15
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [DATA_W-1:0]  result;
        logic               cmp;
        logic               dz;
        logic               neg;
        logic [DATA_W-1:0]  den;
        logic [DATA_W-1:0]  rem;
        logic [DIV_W-1:0]   num;
    } stage_t;

endpackage

>>> rtl/fixed_point_alu_top.sv
// Pipelined signed fixed-point ALU: add, sub, mul, div, compares, min/max, inc/dec and conversions.
// Depends on fap_pkg for the mode codes, widths and the stage payload type.
//
// One beat is taken on every clock edge where start is high. busy is always low, since
// every mode flows through the same fixed-length pipeline and nothing stalls it. Each
// result is shown for one cycle, marked by a single-cycle done strobe, in input order.
// It passes through the input register, the operand stage, the divider stages and the
// output register, in that order. Back-to-back beats come out as back-to-back results,
// and the receiver cannot hold results off. The length is set by the divider, which
// resolves one quotient bit per stage over the 40-bit widened dividend; the other modes
// ride along beside it.
module fixed_point_alu_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  mode,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic        done,
    output logic signed [31:0] result_value,
    output logic        compare_true,
    output logic        divide_by_zero
);

    // Input register.
    logic                in_vld_reg;
    fap_pkg::mode_t      mode_reg;
    logic signed [31:0]  a_reg;
    logic signed [31:0]  b_reg;

    // Operand stage and divider stages.
    logic [fap_pkg::DIV_W:0]   vld_reg;
    fap_pkg::stage_t           stg_reg  [fap_pkg::DIV_W+1];
    fap_pkg::stage_t           stg0_next;
    fap_pkg::stage_t           stg_next [fap_pkg::DIV_W];
    logic signed [63:0]        prod_reg;
    logic signed [63:0]        prod_next;
    logic [fap_pkg::DATA_W:0]  trial    [fap_pkg::DIV_W];
    logic [fap_pkg::DATA_W:0]  diff     [fap_pkg::DIV_W];
    logic signed [63:0]        prod_shift;

    // Output register.
    logic                done_reg;
    logic [31:0]         result_reg;
    logic [31:0]         result_next;
    logic                cmp_reg;
    logic                dz_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            vld_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start;
            vld_reg    <= {vld_reg[fap_pkg::DIV_W-1:0], in_vld_reg};
            done_reg   <= vld_reg[fap_pkg::DIV_W];
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= fap_pkg::mode_t'(mode);
        a_reg      <= operand_a;
        b_reg      <= operand_b;
        stg_reg[0] <= stg0_next;
        prod_reg   <= prod_next;
        for (int j = 0; j < fap_pkg::DIV_W; j++)
        begin
            stg_reg[j+1] <= stg_next[j];
        end
        result_reg <= result_next;
        cmp_reg    <= stg_reg[fap_pkg::DIV_W].cmp;
        dz_reg     <= stg_reg[fap_pkg::DIV_W].dz;
    end

    // Operand stage: every mode but mul and div finishes here.
    always_comb
    begin
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        mag_a = a_reg[31] ? (32'd0 - a_reg) : a_reg;
        mag_b = b_reg[31] ? (32'd0 - b_reg) : b_reg;
        prod_next        = a_reg * b_reg;
        stg0_next        = '0;
        stg0_next.mode   = mode_reg;
        stg0_next.neg    = a_reg[31] ^ b_reg[31];
        stg0_next.den    = mag_b;
        stg0_next.num    = {mag_a, {fap_pkg::FRAC_BITS{1'b0}}};
        unique case (mode_reg)
            fap_pkg::MODE_ADD:     stg0_next.result = a_reg + b_reg;
            fap_pkg::MODE_SUB:     stg0_next.result = a_reg - b_reg;
            fap_pkg::MODE_MUL:     stg0_next.result = '0;
            fap_pkg::MODE_DIV:     stg0_next.dz     = (b_reg == 32'sd0);
            fap_pkg::MODE_GT:      stg0_next.cmp    = (a_reg > b_reg);
            fap_pkg::MODE_LT:      stg0_next.cmp    = (a_reg < b_reg);
            fap_pkg::MODE_GE:      stg0_next.cmp    = (a_reg >= b_reg);
            fap_pkg::MODE_LE:      stg0_next.cmp    = (a_reg <= b_reg);
            fap_pkg::MODE_EQ:      stg0_next.cmp    = (a_reg == b_reg);
            fap_pkg::MODE_NE:      stg0_next.cmp    = (a_reg != b_reg);
            fap_pkg::MODE_MIN:     stg0_next.result = (a_reg < b_reg) ? a_reg : b_reg;
            fap_pkg::MODE_MAX:     stg0_next.result = (a_reg > b_reg) ? a_reg : b_reg;
            fap_pkg::MODE_INC:     stg0_next.result = a_reg + 32'sd1;
            fap_pkg::MODE_DEC:     stg0_next.result = a_reg - 32'sd1;
            fap_pkg::MODE_TOINT:   stg0_next.result = a_reg >>> fap_pkg::FRAC_BITS;
            fap_pkg::MODE_FROMINT: stg0_next.result = a_reg << fap_pkg::FRAC_BITS;
            default:               stg0_next.result = '0;
        endcase
    end

    assign prod_shift = prod_reg >>> fap_pkg::FRAC_BITS;

    // Restoring divider on magnitudes, one quotient bit per stage. The quotient bits
    // shift into the bottom of num as the dividend bits leave its top.
    always_comb
    begin
        for (int j = 0; j < fap_pkg::DIV_W; j++)
        begin
            stg_next[j] = stg_reg[j];
            trial[j]    = {stg_reg[j].rem, stg_reg[j].num[fap_pkg::DIV_W-1]};
            diff[j]     = trial[j] - {1'b0, stg_reg[j].den};
            if (trial[j] >= {1'b0, stg_reg[j].den})
            begin
                stg_next[j].rem = diff[j][fap_pkg::DATA_W-1:0];
                stg_next[j].num = {stg_reg[j].num[fap_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                stg_next[j].rem = trial[j][fap_pkg::DATA_W-1:0];
                stg_next[j].num = {stg_reg[j].num[fap_pkg::DIV_W-2:0], 1'b0};
            end
            if ((j == 0) && (stg_reg[j].mode == fap_pkg::MODE_MUL))
            begin
                stg_next[j].result = prod_shift[31:0];
            end
        end
    end

    always_comb
    begin
        logic [31:0] quo;
        quo = stg_reg[fap_pkg::DIV_W].num[31:0];
        result_next = stg_reg[fap_pkg::DIV_W].result;
        if (stg_reg[fap_pkg::DIV_W].mode == fap_pkg::MODE_DIV)
        begin
            if (stg_reg[fap_pkg::DIV_W].dz)
                result_next = '0;
            else if (stg_reg[fap_pkg::DIV_W].neg)
                result_next = 32'd0 - quo;
            else
                result_next = quo;
        end
    end

    assign done           = done_reg;
    assign result_value   = result_reg;
    assign compare_true   = cmp_reg;
    assign divide_by_zero = dz_reg;

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_by_zero) |-> (result_value == 32'sd0))
        else $error("divide by zero with nonzero result");
    a_cmp_dz: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(compare_true && divide_by_zero))
        else $error("compare and divide flags both set");
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && compare_true) |-> (result_value == 32'sd0))
        else $error("comparison with nonzero result");
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(vld_reg[fap_pkg::DIV_W]))
        else $error("done without a beat in the last stage");
`endif

endmodule

>>> verif/testbench.sv
// Self-checking testbench for fixed_point_alu_top: directed corner beats, then random beats.
// Depends on fap_pkg and the RTL of fixed_point_alu_top.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic signed [31:0] value;
        logic               cmp;
        logic               dz;
    } alu_out_t;

    int error_count = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH %s", what);
        error_count++;
    endtask

    // Computes the expected outcome of one beat.
    function automatic alu_out_t compute_alu(fap_pkg::mode_t m, logic signed [31:0] a,
                                             logic signed [31:0] b);
        alu_out_t r;
        logic signed [63:0] wide;
        logic signed [63:0] num;
        r.value = '0;
        r.cmp   = 1'b0;
        r.dz    = 1'b0;
        case (m)
            fap_pkg::MODE_ADD: r.value = a + b;
            fap_pkg::MODE_SUB: r.value = a - b;
            fap_pkg::MODE_MUL:
            begin
                wide = 64'(a) * 64'(b);
                wide = wide >>> fap_pkg::FRAC_BITS;
                r.value = wide[31:0];
            end
            fap_pkg::MODE_DIV:
            begin
                if (b == 0)
                begin
                    r.dz = 1'b1;
                end
                else
                begin
                    // SystemVerilog signed division truncates toward zero.
                    num = 64'(a) <<< fap_pkg::FRAC_BITS;
                    wide = num / 64'(b);
                    r.value = wide[31:0];
                end
            end
            fap_pkg::MODE_GT: r.cmp = a > b;
            fap_pkg::MODE_LT: r.cmp = a < b;
            fap_pkg::MODE_GE: r.cmp = a >= b;
            fap_pkg::MODE_LE: r.cmp = a <= b;
            fap_pkg::MODE_EQ: r.cmp = a == b;
            fap_pkg::MODE_NE: r.cmp = a != b;
            fap_pkg::MODE_MIN: r.value = (a < b) ? a : b;
            fap_pkg::MODE_MAX: r.value = (a > b) ? a : b;
            fap_pkg::MODE_INC: r.value = a + 1;
            fap_pkg::MODE_DEC: r.value = a - 1;
            fap_pkg::MODE_TOINT: r.value = a >>> fap_pkg::FRAC_BITS;
            default: r.value = a << fap_pkg::FRAC_BITS;
        endcase
        return r;
    endfunction

    class alu_scoreboard;
        alu_out_t pending[$];

        function void note_beat(fap_pkg::mode_t m, logic signed [31:0] a,
                                logic signed [31:0] b);
            pending.push_back(compute_alu(m, a, b));
        endfunction

        task check_result(logic signed [31:0] v, logic c, logic z);
            alu_out_t e;
            if (pending.size() == 0)
            begin
                report_mismatch("result with nothing pending");
                return;
            end
            e = pending.pop_front();
            if (v !== e.value)
                report_mismatch($sformatf("result_value %h, predicted %h", v, e.value));
            if (c !== e.cmp)
                report_mismatch($sformatf("compare_true %b, predicted %b", c, e.cmp));
            if (z !== e.dz)
                report_mismatch($sformatf("divide_by_zero %b, predicted %b", z, e.dz));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [3:0] mode = '0;
    logic signed [31:0] operand_a = '0;
    logic signed [31:0] operand_b = '0;
    logic busy, done, compare_true, divide_by_zero;
    logic signed [31:0] result_value;

    alu_scoreboard board = new();
    int unsigned cycle_count = 0;

    fixed_point_alu_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .operand_a(operand_a), .operand_b(operand_b), .done(done),
        .result_value(result_value), .compare_true(compare_true),
        .divide_by_zero(divide_by_zero)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && start && !busy)
            board.note_beat(fap_pkg::mode_t'(mode), operand_a, operand_b);
        if (rst_n && done)
            board.check_result(result_value, compare_true, divide_by_zero);
        if (cycle_count > 200000)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Presents one beat and holds it until accepted; start stays high into the next beat.
    task automatic send_beat(fap_pkg::mode_t m, logic signed [31:0] a,
                             logic signed [31:0] b);
        mode      <= m;
        operand_a <= a;
        operand_b <= b;
        start     <= 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic idle_gap(int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return $signed(32'($urandom_range(0, 1023))) - 512;
            4: return $signed(32'($urandom_range(0, 1 << 20)));
            default: return $signed($urandom);
        endcase
    endfunction

    logic signed [31:0] corners [6] = '{32'sh7FFFFFFF, 32'sh80000000, 0, -1, 256, -256};

    initial
    begin
        fap_pkg::mode_t m;
        logic signed [31:0] a, b;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Every mode on extreme operands, including division by zero and divide overflow.
        for (int k = 0; k < 16; k++)
            send_beat(fap_pkg::mode_t'(k), corners[k % 6], corners[(k + 3) % 6]);
        send_beat(fap_pkg::MODE_DIV, 32'sh80000000, -1);
        send_beat(fap_pkg::MODE_DIV, 1000, 0);
        send_beat(fap_pkg::MODE_MUL, 32'sh80000000, 32'sh80000000);
        send_beat(fap_pkg::MODE_MIN, 5, 5);
        send_beat(fap_pkg::MODE_MAX, -7, -7);
        send_beat(fap_pkg::MODE_TOINT, -1, 0);
        send_beat(fap_pkg::MODE_DIV, -255, 256);
        idle_gap(1);

        // Hold off until the pipeline has drained completely.
        while (board.pending.size() != 0) @(negedge clk);

        for (int n = 0; n < 800; n++)
        begin
            m = fap_pkg::mode_t'($urandom_range(0, 15));
            a = pick_operand();
            b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
            if (m == fap_pkg::MODE_DIV && $urandom_range(0, 7) == 0)
                b = 0;
            send_beat(m, a, b);
            if (n < 650 && $urandom_range(0, 5) == 0)
                idle_gap($urandom_range(1, 11));
        end
        start <= 1'b0;

        while (board.pending.size() != 0) @(negedge clk);
        repeat (fap_pkg::LATENCY + 5) @(negedge clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

>>> filelist.f
rtl/fap_pkg.sv
rtl/fixed_point_alu_top.sv
verif/testbench.sv
